// File: rtl/adaptive_delta_modulator_defines.svh
// Assertion macros used by the RTL core of the block.
`ifndef ADAPTIVE_DELTA_MODULATOR_DEFINES_SVH
`define ADAPTIVE_DELTA_MODULATOR_DEFINES_SVH

`ifndef SYNTH
`define ADM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adm: assertion failed");
`define ADM_ASSERT_NEVER(label, cond) \
  `ADM_ASSERT(label, !(cond))
`else
`define ADM_ASSERT(label, prop)
`define ADM_ASSERT_NEVER(label, cond)
`endif

`endif

// File: rtl/adm_pkg.sv
package adm_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned PredWidth   = 24;
  localparam int unsigned StepWidth   = 20;
  localparam int unsigned FracBits    = 8;

  localparam logic [StepWidth-1:0] StepInitialReset = 20'd256;
  localparam logic [StepWidth-1:0] StepFloorReset   = 20'd64;
  localparam logic [StepWidth-1:0] StepCeilingReset = 20'd65536;

  localparam logic signed [PredWidth-1:0] PredMax = 24'sh7FFFFF;
  localparam logic signed [PredWidth-1:0] PredMin = -24'sh800000;

  // Division by three of a 21-bit value: floor(x * DivThreeRecip / 2**DivThreeShift).
  localparam int unsigned DivThreeShift = 22;
  localparam logic [StepWidth:0] DivThreeRecip = 21'd1398102;

  localparam logic [1:0] RunSat = 2'd3;

  typedef enum logic [1:0] {
    RegMode        = 2'd0,
    RegStepInitial = 2'd1,
    RegStepFloor   = 2'd2,
    RegStepCeiling = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                 mode;
    logic [StepWidth-1:0] step_initial;
    logic [StepWidth-1:0] step_floor;
    logic [StepWidth-1:0] step_ceiling;
  } cfg_t;

  typedef struct packed {
    logic                          cmd;
    logic signed [SampleWidth-1:0] sample_in;
    logic                          bit_in;
  } item_t;

  typedef struct packed {
    logic                        bit_out;
    logic signed [PredWidth-1:0] estimate;
    logic [StepWidth-1:0]        step_now;
  } result_t;

endpackage

// File: rtl/adm_core.sv
`include "adaptive_delta_modulator_defines.svh"

module adm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  adm_pkg::cfg_t   cfg_i,
  input  adm_pkg::item_t  item_i,
  input  logic            advance_i,
  output adm_pkg::result_t result_o
);

  localparam int unsigned SW = adm_pkg::StepWidth;
  localparam int unsigned PW = adm_pkg::PredWidth;
  localparam int unsigned ProdWidth = 2 * (SW + 1);

  logic signed [PW-1:0] pred_q, pred_d;
  logic [SW-1:0]        step_q, step_d;
  logic                 primed_q, primed_d;
  logic                 prev_q, prev_d;
  logic [1:0]           run_q, run_d;

  logic signed [PW-1:0] sample_fx;
  logic                 encode;
  logic                 priming;
  logic                 dbit;
  logic signed [PW:0]   moved;
  logic signed [PW-1:0] moved_sat;
  logic                 same;
  logic [1:0]           run_inc;
  logic                 mul_sel;
  logic [SW:0]          up;
  logic [SW-1:0]        up_clamped;
  logic [SW:0]          twice;
  logic [ProdWidth-1:0] prod;
  logic [SW-1:0]        quo;
  logic [SW-1:0]        down_clamped;
  logic [SW-1:0]        step_adapted;

  always_comb begin
    sample_fx = {item_i.sample_in, {adm_pkg::FracBits{1'b0}}};
    encode    = ~cfg_i.mode;
    priming   = ~item_i.cmd & encode & ~primed_q;
    dbit      = encode ? (sample_fx > pred_q) : item_i.bit_in;

    if (dbit) begin
      moved = {pred_q[PW-1], pred_q} + $signed({{(PW + 1 - SW){1'b0}}, step_q});
    end else begin
      moved = {pred_q[PW-1], pred_q} - $signed({{(PW + 1 - SW){1'b0}}, step_q});
    end
    if (moved[PW] != moved[PW-1]) begin
      moved_sat = moved[PW] ? adm_pkg::PredMin : adm_pkg::PredMax;
    end else begin
      moved_sat = moved[PW-1:0];
    end

    same    = (dbit == prev_q);
    run_inc = (run_q == adm_pkg::RunSat) ? adm_pkg::RunSat : run_q + 2'd1;
    mul_sel = same && (run_inc == adm_pkg::RunSat);

    up         = {1'b0, step_q} + {2'b0, step_q[SW-1:1]};
    up_clamped = (up > {1'b0, cfg_i.step_ceiling}) ? cfg_i.step_ceiling : up[SW-1:0];

    twice        = {step_q, 1'b0};
    prod         = ProdWidth'(twice) * ProdWidth'(adm_pkg::DivThreeRecip);
    quo          = prod[adm_pkg::DivThreeShift +: SW];
    down_clamped = (quo < cfg_i.step_floor) ? cfg_i.step_floor : quo;

    if (!same) begin
      step_adapted = down_clamped;
    end else if (mul_sel) begin
      step_adapted = up_clamped;
    end else begin
      step_adapted = step_q;
    end
  end

  always_comb begin
    pred_d   = pred_q;
    step_d   = step_q;
    primed_d = primed_q;
    prev_d   = prev_q;
    run_d    = run_q;
    result_o.bit_out  = 1'b0;
    result_o.estimate = pred_q;
    result_o.step_now = step_q;
    if (item_i.cmd) begin
      pred_d   = '0;
      step_d   = cfg_i.step_initial;
      primed_d = 1'b0;
    end else if (priming) begin
      pred_d   = sample_fx;
      primed_d = 1'b1;
    end else begin
      pred_d = moved_sat;
      step_d = step_adapted;
      prev_d = dbit;
      run_d  = same ? run_inc : 2'd1;
      result_o.bit_out = dbit;
    end
    result_o.estimate = pred_d;
    result_o.step_now = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q   <= '0;
      step_q   <= adm_pkg::StepInitialReset;
      primed_q <= 1'b1;
      prev_q   <= 1'b0;
      run_q    <= '0;
    end else if (advance_i) begin
      pred_q   <= pred_d;
      step_q   <= step_d;
      primed_q <= primed_d;
      prev_q   <= prev_d;
      run_q    <= run_d;
    end
  end

  `ADM_ASSERT(run_nonzero_after_bit, advance_i && !item_i.cmd && !priming |=> run_q != 2'd0)
  `ADM_ASSERT(restart_clears, advance_i && item_i.cmd |=> pred_q == '0 && !primed_q)
  `ADM_ASSERT(ceiling_after_mul,
              advance_i && !item_i.cmd && !priming && mul_sel |=>
              step_q <= $past(cfg_i.step_ceiling))

endmodule

// File: rtl/adaptive_delta_modulator.sv
// One-bit adaptive delta modulator. With mode 0 each 16-bit sample is compared
// with the Q16.8 predictor and a delta bit is produced; with mode 1 each received
// bit drives the predictor. The step grows by 1.5 after three equal bits and
// shrinks by 1.5 on a change of bit, clamped to the configured ceiling and floor.
// A restart item clears the predictor and reloads the initial step; the next
// encode sample then primes the predictor. Registers on the APB port: mode at
// 0x0, step_initial at 0x4, step_floor at 0x8, step_ceiling at 0xC. The block
// takes one item per clock cycle while the result register is free or is being
// emptied. An item is held in the input register and then moves into the result
// register, from which its result is offered. A result that is not taken holds
// the input register, which then accepts no further item until the result is
// taken. The step adaptation with its reciprocal multiply for the division by
// three sets the longest path.
module adaptive_delta_modulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic signed [15:0]  sample_in_i,
  input  logic                bit_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                bit_out_o,
  output logic signed [23:0]  estimate_o,
  output logic [19:0]         step_now_o
);

  localparam int unsigned SW = adm_pkg::StepWidth;

  adm_pkg::cfg_t    cfg_q;
  adm_pkg::reg_idx_e reg_idx;
  logic             cfg_wr;

  adm_pkg::item_t   in_q;
  logic             in_valid_q;
  adm_pkg::result_t res;
  adm_pkg::result_t out_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_xfer;

  assign pready  = 1'b1;
  assign reg_idx = adm_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      adm_pkg::RegMode:        prdata = {31'b0, cfg_q.mode};
      adm_pkg::RegStepInitial: prdata = {{(32 - SW){1'b0}}, cfg_q.step_initial};
      adm_pkg::RegStepFloor:   prdata = {{(32 - SW){1'b0}}, cfg_q.step_floor};
      adm_pkg::RegStepCeiling: prdata = {{(32 - SW){1'b0}}, cfg_q.step_ceiling};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= 1'b0;
      cfg_q.step_initial <= adm_pkg::StepInitialReset;
      cfg_q.step_floor   <= adm_pkg::StepFloorReset;
      cfg_q.step_ceiling <= adm_pkg::StepCeilingReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        adm_pkg::RegMode:        cfg_q.mode         <= pwdata[0];
        adm_pkg::RegStepInitial: cfg_q.step_initial <= pwdata[SW-1:0];
        adm_pkg::RegStepFloor:   cfg_q.step_floor   <= pwdata[SW-1:0];
        adm_pkg::RegStepCeiling: cfg_q.step_ceiling <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // An item moves on whenever the result register is free or is being emptied.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.cmd       <= cmd_i;
      in_q.sample_in <= sample_in_i;
      in_q.bit_in    <= bit_in_i;
    end
  end

  adm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_i    (in_q),
    .advance_i (advance),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_out_o   = out_q.bit_out;
  assign estimate_o  = out_q.estimate;
  assign step_now_o  = out_q.step_now;

endmodule

// File: sim/adaptive_delta_modulator_tb.sv
`timescale 1ns / 1ps

module adaptive_delta_modulator_tb;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;
  localparam logic CmdProcess = 1'b0;
  localparam logic CmdRestart = 1'b1;
  localparam int unsigned StepMax = 32'h000F_FFFF;

  class delta_mod_tracker;
    logic             mode;
    int unsigned      init_step;
    int unsigned      floor_lim;
    int unsigned      ceil_lim;
    int               pred;
    int unsigned      step;
    bit               primed;
    logic             last_bit;
    int unsigned      run_len;
    adm_pkg::result_t pending[$];
    int unsigned      fail_count;

    function new();
      mode       = ModeEncode;
      init_step  = adm_pkg::StepInitialReset;
      floor_lim  = adm_pkg::StepFloorReset;
      ceil_lim   = adm_pkg::StepCeilingReset;
      pred       = 0;
      step       = init_step;
      primed     = 1'b1;
      last_bit   = 1'b0;
      run_len    = 0;
      fail_count = 0;
    endfunction

    function void set_reg(adm_pkg::reg_idx_e idx, int unsigned val);
      case (idx)
        adm_pkg::RegMode:        mode = val[0];
        adm_pkg::RegStepInitial: init_step = val & StepMax;
        adm_pkg::RegStepFloor:   floor_lim = val & StepMax;
        adm_pkg::RegStepCeiling: ceil_lim = val & StepMax;
        default: ;
      endcase
    endfunction

    function void note_item(logic cmd, logic signed [15:0] sample, logic rx_bit);
      adm_pkg::result_t want;
      logic             dbit;
      int               scaled;
      int unsigned      s;
      dbit   = 1'b0;
      scaled = int'(sample) * 256;
      if (cmd == CmdRestart) begin
        pred   = 0;
        step   = init_step;
        primed = 1'b0;
      end else if (mode == ModeEncode && !primed) begin
        pred   = scaled;
        primed = 1'b1;
      end else begin
        dbit = (mode == ModeEncode) ? (scaled > pred) : rx_bit;
        pred = dbit ? pred + int'(step) : pred - int'(step);
        if (pred > int'(adm_pkg::PredMax)) pred = int'(adm_pkg::PredMax);
        if (pred < int'(adm_pkg::PredMin)) pred = int'(adm_pkg::PredMin);
        s = step;
        if (dbit == last_bit) begin
          if (run_len < adm_pkg::RunSat) run_len++;
          if (run_len > 2) begin
            s = s + (s >> 1);
            if (s > ceil_lim) s = ceil_lim;
          end
        end else begin
          run_len = 1;
          s = (2 * s) / 3;
          if (s < floor_lim) s = floor_lim;
        end
        step     = s & StepMax;
        last_bit = dbit;
      end
      want.bit_out  = dbit;
      want.estimate = pred[adm_pkg::PredWidth-1:0];
      want.step_now = step[adm_pkg::StepWidth-1:0];
      pending.push_back(want);
    endfunction

    function void check_result(adm_pkg::result_t got);
      adm_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: bit_out %0d estimate %0d step_now %0d",
               got.bit_out, $signed(got.estimate), got.step_now);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (got.bit_out !== want.bit_out) begin
        $error("bit_out: expected %0d, actual %0d", want.bit_out, got.bit_out);
        fail_count++;
      end
      if (got.estimate !== want.estimate) begin
        $error("estimate: expected %0d, actual %0d", $signed(want.estimate),
               $signed(got.estimate));
        fail_count++;
      end
      if (got.step_now !== want.step_now) begin
        $error("step_now: expected %0d, actual %0d", want.step_now, got.step_now);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = 1'b0;
  logic signed [15:0] sample_in_i = '0;
  logic               bit_in_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               bit_out_o;
  logic signed [23:0] estimate_o;
  logic [19:0]        step_now_o;

  delta_mod_tracker tracker;
  adm_pkg::result_t seen_result;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int               hold_req = 0;
  int               hold_left = 0;
  int               walk = 0;
  int               span = 64;
  int               run_left = 0;
  logic             run_bit = 1'b0;

  adaptive_delta_modulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .sample_in_i (sample_in_i),
    .bit_in_i    (bit_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bit_out_o   (bit_out_o),
    .estimate_o  (estimate_o),
    .step_now_o  (step_now_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.bit_out  = bit_out_o;
      seen_result.estimate = estimate_o;
      seen_result.step_now = step_now_o;
      tracker.check_result(seen_result);
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic cmd, logic signed [15:0] sample, logic rx_bit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    sample_in_i <= sample;
    bit_in_i    <= rx_bit;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_item(cmd, sample, rx_bit);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(adm_pkg::reg_idx_e idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_item();
    logic               cmd;
    logic signed [15:0] smp;
    logic               rx_bit;
    cmd = ($urandom_range(99) < 3) ? CmdRestart : CmdProcess;
    if ($urandom_range(99) < 15) begin
      smp = 16'($urandom);
    end else begin
      walk = walk + int'($urandom_range(2 * span)) - span;
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
      smp = walk[15:0];
    end
    if (run_left == 0) begin
      run_bit  = 1'($urandom_range(1));
      run_left = $urandom_range(1, 8);
    end
    run_left--;
    rx_bit = ($urandom_range(99) < 15) ? 1'($urandom_range(1)) : run_bit;
    send_item(cmd, smp, rx_bit);
  endtask

  initial begin
    int unsigned init_val;
    int unsigned floor_val;
    int unsigned ceil_val;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CmdProcess, 16'sh0000, 1'b0);
    repeat (4) send_item(CmdProcess, 16'sh7FFF, 1'b1);
    repeat (3) send_item(CmdProcess, 16'sh8000, 1'b0);
    repeat (2) send_item(CmdRestart, 16'sh7FFF, 1'b1);
    send_item(CmdProcess, 16'sh8000, 1'b0);
    send_item(CmdProcess, 16'sh8000, 1'b1);
    send_item(CmdProcess, 16'sh7FFF, 1'b0);

    settle();
    apb_write(adm_pkg::RegMode, ModeDecode);
    apb_write(adm_pkg::RegStepInitial, StepMax);
    apb_write(adm_pkg::RegStepFloor, 1);
    apb_write(adm_pkg::RegStepCeiling, StepMax);
    send_item(CmdRestart, 16'sh0000, 1'b0);
    repeat (9) send_item(CmdProcess, 16'sh8000, 1'b1);
    send_item(CmdProcess, 16'sh7FFF, 1'b0);
    send_item(CmdProcess, 16'sh0000, 1'b1);

    for (int k = 0; k < 8; k++) begin
      settle();
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case ($urandom_range(3))
        0: init_val = 1;
        1: init_val = StepMax;
        2: init_val = $urandom_range(16, 4096);
        default: init_val = $urandom_range(1, StepMax);
      endcase
      case ($urandom_range(2))
        0: floor_val = 1;
        1: floor_val = $urandom_range(1, 512);
        default: floor_val = $urandom_range(1, StepMax);
      endcase
      case ($urandom_range(2))
        0: ceil_val = StepMax;
        1: ceil_val = $urandom_range(1024, 65536);
        default: ceil_val = $urandom_range(1, StepMax);
      endcase
      // Ceiling below floor lets the step escape both limits.
      if (k == 5) begin
        floor_val = 5000;
        ceil_val  = 100;
      end
      if (k == 6) floor_val = StepMax;
      case ($urandom_range(2))
        0: span = 16;
        1: span = 512;
        default: span = 8192;
      endcase
      apb_write(adm_pkg::RegMode, (k % 2 == 1) ? ModeDecode : ModeEncode);
      apb_write(adm_pkg::RegStepInitial, init_val);
      apb_write(adm_pkg::RegStepFloor, floor_val);
      apb_write(adm_pkg::RegStepCeiling, ceil_val);

      for (int i = 0; i < 250; i++) begin
        if (k == 3 && i == 100) begin
          send_idle_pct = 0;
          hold_req      = 80;
        end
        if (k == 3 && i == 160) send_idle_pct = 8;
        if (k == 6 && i == 125) settle();
        random_item();
      end
    end

    settle();
    if (tracker.fail_count == 0) begin
      $display("adaptive_delta_modulator: match");
    end else begin
      $display("adaptive_delta_modulator: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("adaptive_delta_modulator: mismatch");
    $finish;
  end

endmodule
